@@ design/cms_pkg.sv @@
// shared types and constants for the coap message serializer
// used by cms_front, cms_queue, cms_back and the top level; no dependencies
package cms_pkg;

  localparam int unsigned MaxPayloadBytes = 1024;
  localparam int unsigned MaxOptionBytes  = 1024;
  localparam int unsigned CountMax        = 2047;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QPtrW           = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_OPT_HDR = 3'd1,
    CMD_OPT_VAL = 3'd2,
    CMD_PAYLOAD = 3'd3,
    CMD_FINISH  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TOKEN   = 3'd1,
    ST_CLASS   = 3'd2,
    ST_LARGE   = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_OPTLONG = 3'd5,
    ST_ORDER   = 3'd6
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MSG_TYPE    = 3'd0,
    REG_MSG_CODE    = 3'd1,
    REG_MSG_ID      = 3'd2,
    REG_TOKEN_LEN   = 3'd3,
    REG_TOKEN_VALUE = 3'd4
  } reg_idx_t;

  // what the back end has to emit for one accepted item
  typedef enum logic [2:0] {
    JOB_START  = 3'd0,
    JOB_OPTION = 3'd1,
    JOB_BYTE   = 3'd2,
    JOB_MARK   = 3'd3,
    JOB_NOBYTE = 3'd4
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [3:0]  last_idx;
    logic [7:0]  head;
    logic [31:0] ext;
    logic [7:0]  data;
    status_t     status;
  } job_t;

endpackage

@@ design/cms_front.sv @@
// front end: accepts command beats, checks them against message state, builds jobs
// depends on cms_pkg
module cms_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [2:0]      command,
  input  logic [15:0]     option_number,
  input  logic [15:0]     option_length,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      msg_code,
  input  logic [3:0]      token_len,
  output logic            push,
  output cms_pkg::job_t   job
);

  logic [15:0] previous_option, previous_option_next;
  logic [10:0] payload_count, payload_count_next;
  logic        marker_sent, marker_sent_next;
  logic        failed, failed_next;

  logic [2:0]  cls;
  logic        class_ok, code_empty, opt_long, pay_full, order_bad;
  logic [15:0] delta, d_word, l_word, d_tmp, l_tmp;
  logic [3:0]  d_code, l_code;
  logic [1:0]  d_n, l_n;
  logic [31:0] ext;

  assign cls        = msg_code[7:5];
  assign class_ok   = (cls == 3'd0) || (cls == 3'd2) || (cls == 3'd4) || (cls == 3'd5);
  assign code_empty = (msg_code == 8'd0);
  assign opt_long   = 17'(option_length) > 17'(cms_pkg::MaxOptionBytes);
  assign pay_full   = 17'(payload_count) >= 17'(cms_pkg::MaxPayloadBytes);
  assign order_bad  = option_number < previous_option;
  assign delta      = option_number - previous_option;

  // nibble codes with 13 / 14 extensions
  always_comb begin
    d_tmp  = delta - 16'd13;
    d_code = delta[3:0];
    d_n    = 2'd0;
    d_word = 16'd0;
    if (delta >= 16'd269) begin
      d_code = 4'd14;
      d_n    = 2'd2;
      d_word = delta - 16'd269;
    end else if (delta >= 16'd13) begin
      d_code = 4'd13;
      d_n    = 2'd1;
      d_word = {d_tmp[7:0], 8'd0};
    end
    l_tmp  = option_length - 16'd13;
    l_code = option_length[3:0];
    l_n    = 2'd0;
    l_word = 16'd0;
    if (option_length >= 16'd269) begin
      l_code = 4'd14;
      l_n    = 2'd2;
      l_word = option_length - 16'd269;
    end else if (option_length >= 16'd13) begin
      l_code = 4'd13;
      l_n    = 2'd1;
      l_word = {l_tmp[7:0], 8'd0};
    end
    ext = {d_word, 16'd0} | ({l_word, 16'd0} >> {d_n, 3'b000});
  end

  always_comb begin
    previous_option_next = previous_option;
    payload_count_next   = payload_count;
    marker_sent_next     = marker_sent;
    failed_next          = failed;
    push                 = 1'b0;
    job                  = '0;
    job.kind             = cms_pkg::JOB_NOBYTE;
    job.status           = cms_pkg::ST_OK;
    job.data             = data_byte;
    if (accept) begin
      priority if (command == cms_pkg::CMD_START) begin
        previous_option_next = 16'd0;
        payload_count_next   = 11'd0;
        marker_sent_next     = 1'b0;
        failed_next          = 1'b1;
        push                 = 1'b1;
        priority if (token_len > 4'd8) begin
          job.status = cms_pkg::ST_TOKEN;
        end else if (!class_ok) begin
          job.status = cms_pkg::ST_CLASS;
        end else if (code_empty && (token_len != 4'd0)) begin
          job.status = cms_pkg::ST_EMPTY;
        end else begin
          failed_next  = 1'b0;
          job.kind     = cms_pkg::JOB_START;
          job.last_idx = 4'd3 + token_len;
        end
      end else if ((command > cms_pkg::CMD_FINISH) || failed) begin
        push = 1'b0;
      end else if (command == cms_pkg::CMD_FINISH) begin
        push = 1'b1;
      end else begin
        push = 1'b1;
        // errors are all one no-byte result that latches failed
        failed_next = 1'b1;
        priority if (code_empty) begin
          job.status = cms_pkg::ST_EMPTY;
        end else if (command == cms_pkg::CMD_OPT_HDR) begin
          priority if (marker_sent) begin
            job.status = cms_pkg::ST_ORDER;
          end else if (opt_long) begin
            job.status = cms_pkg::ST_OPTLONG;
          end else if (order_bad) begin
            job.status = cms_pkg::ST_ORDER;
          end else begin
            failed_next          = 1'b0;
            previous_option_next = option_number;
            job.kind             = cms_pkg::JOB_OPTION;
            job.head             = {d_code, l_code};
            job.ext              = ext;
            job.last_idx         = 4'(d_n) + 4'(l_n);
          end
        end else if (command == cms_pkg::CMD_OPT_VAL) begin
          if (marker_sent) begin
            job.status = cms_pkg::ST_ORDER;
          end else begin
            failed_next = 1'b0;
            job.kind    = cms_pkg::JOB_BYTE;
          end
        end else begin
          if (pay_full) begin
            job.status = cms_pkg::ST_LARGE;
          end else begin
            failed_next      = 1'b0;
            marker_sent_next = 1'b1;
            if (payload_count != 11'(cms_pkg::CountMax)) begin
              payload_count_next = payload_count + 11'd1;
            end
            if (marker_sent) begin
              job.kind = cms_pkg::JOB_BYTE;
            end else begin
              job.kind     = cms_pkg::JOB_MARK;
              job.last_idx = 4'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_option <= 16'd0;
      payload_count   <= 11'd0;
      marker_sent     <= 1'b0;
      failed          <= 1'b0;
    end else begin
      previous_option <= previous_option_next;
      payload_count   <= payload_count_next;
      marker_sent     <= marker_sent_next;
      failed          <= failed_next;
    end
  end

endmodule

@@ design/cms_queue.sv @@
// small job queue between the front and back ends
// depends on cms_pkg
module cms_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cms_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output cms_pkg::job_t head_job
);

  cms_pkg::job_t entries [cms_pkg::QueueDepth];
  logic [cms_pkg::QPtrW-1:0] wr_ptr, rd_ptr;
  logic [cms_pkg::QPtrW:0]   count;

  assign full       = (count == (cms_pkg::QPtrW+1)'(cms_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (cms_pkg::QPtrW+1)'(push) - (cms_pkg::QPtrW+1)'(pop);
    end
  end

endmodule

@@ design/cms_back.sv @@
// back end: expands one job into output beats, one byte per cycle unless out_ready stalls the output
// depends on cms_pkg; holds the output register
module cms_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  cms_pkg::job_t head_job,
  output logic          pop,
  input  logic [1:0]    msg_type,
  input  logic [7:0]    msg_code,
  input  logic [15:0]   msg_id,
  input  logic [3:0]    token_len,
  input  logic [63:0]   token_value,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic [2:0]    status,
  output logic          last
);

  logic [3:0]  idx;
  logic        load, at_end;
  logic [7:0]  byte_sel;
  logic        valid_sel;
  logic [3:0]  sh4;
  logic [2:0]  sh;
  logic [3:0]  ext_k;
  logic [31:0] ext_sh;

  assign load   = head_valid && (!out_valid || out_ready);
  assign at_end = (idx == head_job.last_idx);
  assign pop    = load && at_end;

  always_comb begin
    sh4       = token_len + 4'd3 - idx;
    sh        = sh4[2:0];
    ext_k     = idx - 4'd1;
    ext_sh    = head_job.ext << {ext_k[1:0], 3'b000};
    byte_sel  = 8'd0;
    valid_sel = 1'b1;
    unique case (head_job.kind)
      cms_pkg::JOB_START: begin
        unique case (idx)
          4'd0:    byte_sel = {2'b01, msg_type, token_len};
          4'd1:    byte_sel = msg_code;
          4'd2:    byte_sel = msg_id[15:8];
          4'd3:    byte_sel = msg_id[7:0];
          default: byte_sel = token_value[{sh, 3'b000} +: 8];
        endcase
      end
      cms_pkg::JOB_OPTION: byte_sel = (idx == 4'd0) ? head_job.head : ext_sh[31:24];
      cms_pkg::JOB_BYTE:   byte_sel = head_job.data;
      cms_pkg::JOB_MARK:   byte_sel = (idx == 4'd0) ? 8'hFF : head_job.data;
      default:             valid_sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_end ? 4'd0 : idx + 4'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= byte_sel;
      byte_valid <= valid_sel;
      status     <= head_job.status;
      last       <= at_end;
    end
  end

endmodule

@@ design/coap_message_serializer.sv @@
// coap message serializer: a taken command beat is registered in the job queue,
// and the back end then walks it into the output register, one beat per cycle;
// a good start runs 4 to 12 beats, an option header 1 to 5; command beats are
// taken every cycle while the 4-entry job queue has room; the back end drains
// one output beat per cycle while out_ready is high; rst (synchronous) clears
// message state, queue pointers and out_valid and zeroes all config registers
module coap_message_serializer (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [15:0] option_number,
  input  logic [15:0] option_length,
  input  logic [7:0]  data_byte,
  // byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [2:0]  status,
  output logic        last
);

  logic [1:0]  msg_type;
  logic [7:0]  msg_code;
  logic [15:0] msg_id;
  logic [3:0]  token_len;
  logic [63:0] token_value;

  logic          accept, push, pop, full, head_valid;
  cms_pkg::job_t push_job, head_job;

  // config registers; user must write only while the block is idle, not checked
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_type    <= 2'd0;
      msg_code    <= 8'd0;
      msg_id      <= 16'd0;
      token_len   <= 4'd0;
      token_value <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cms_pkg::REG_MSG_TYPE:    msg_type    <= cfg_data[1:0];
        cms_pkg::REG_MSG_CODE:    msg_code    <= cfg_data[7:0];
        cms_pkg::REG_MSG_ID:      msg_id      <= cfg_data[15:0];
        cms_pkg::REG_TOKEN_LEN:   token_len   <= cfg_data[3:0];
        cms_pkg::REG_TOKEN_VALUE: token_value <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // a command beat is taken whenever the queue has a free slot, so items
  // that produce nothing (unknown commands, commands after a failure) also flow
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // front: checks and state updates happen at accept time, so the next
  // command sees the state this one leaves regardless of back-end progress
  cms_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (command),
    .option_number (option_number),
    .option_length (option_length),
    .data_byte     (data_byte),
    .msg_code      (msg_code),
    .token_len     (token_len),
    .push          (push),
    .job           (push_job)
  );

  cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: walks each job one byte per beat into the output register;
  // header and token bytes are read straight from configuration
  cms_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .msg_type    (msg_type),
    .msg_code    (msg_code),
    .msg_id      (msg_id),
    .token_len   (token_len),
    .token_value (token_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .status      (status),
    .last        (last)
  );

endmodule

@@ design/cms_checker.sv @@
// port-level checks for the coap message serializer
// depends on cms_pkg; attached to coap_message_serializer by the bind below
module cms_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic [2:0]  status,
  input logic        last
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(status) && $stable(last))
    else $error("output beat changed while stalled");

  // no output beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // error and finish beats carry no byte and end their run
  a_nobyte_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && (out_byte == 8'd0))
    else $error("no-byte beat without last or with data");

  // a failing status never rides on a data byte
  a_status_nobyte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != cms_pkg::ST_OK) |-> !byte_valid)
    else $error("error status on a data beat");

endmodule

bind coap_message_serializer cms_checker u_cms_checker (.*);

@@ tb/coap_message_serializer_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for coap_message_serializer: directed and random command beats
// depends on cms_pkg and the serializer rtl; a scoreboard class predicts every byte beat
module coap_message_serializer_tb;

  localparam int unsigned NumRegs = 5;

  // a command code the block does not decode
  localparam logic [2:0] CmdUnused = 3'd7;
  localparam logic [7:0] PayloadMarker = 8'hFF;

  // receiver stall styles
  localparam int ReadyAlways  = 0;
  localparam int ReadyRandom  = 1;
  localparam int ReadyPattern = 2;

  localparam int ClkHalf = 5;
  localparam int ResetCycles = 11;
  // the job queue is four deep
  localparam int DrainCycles = 30;
  // command beats in the whole run, directed part included
  localparam int unsigned ItemCount = 300;
  // slowest run: ~330 commands, up to 12 beats each behind receiver stalls, plus gaps
  localparam int unsigned CycleLimit = 100000;

  // one expected byte beat
  typedef struct {
    logic [7:0]       data;
    logic             valid;
    cms_pkg::status_t st;
    logic             last;
  } coap_beat_t;

  // predicts the byte beats of the serializer and checks them in order
  class coap_byte_scoreboard;
    logic [1:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] msg_id;
    logic [3:0]  token_len;
    logic [63:0] token_value;
    logic [15:0] prev_option;
    logic [10:0] payload_count;
    bit          marker_sent;
    bit          failed;
    coap_beat_t  expected_bytes[$];
    logic [7:0]  ext_bytes[$];
    int          mismatches;

    function new();
      msg_type      = '0;
      msg_code      = '0;
      msg_id        = '0;
      token_len     = '0;
      token_value   = '0;
      prev_option   = '0;
      payload_count = '0;
      marker_sent   = 1'b0;
      failed        = 1'b0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        cms_pkg::REG_MSG_TYPE:    msg_type    = value[1:0];
        cms_pkg::REG_MSG_CODE:    msg_code    = value[7:0];
        cms_pkg::REG_MSG_ID:      msg_id      = value[15:0];
        cms_pkg::REG_TOKEN_LEN:   token_len   = value[3:0];
        cms_pkg::REG_TOKEN_VALUE: token_value = value;
        default: ;
      endcase
    endfunction

    function void push_beat(logic [7:0] data, logic valid, cms_pkg::status_t st);
      coap_beat_t b;
      b.data  = data;
      b.valid = valid;
      b.st    = st;
      b.last  = 1'b0;
      expected_bytes.insert(expected_bytes.size(), b);
    endfunction

    // an error is a single empty beat and stops the message
    function int raise_error(cms_pkg::status_t st);
      failed = 1'b1;
      push_beat(8'h00, 1'b0, st);
      return 1;
    endfunction

    // 4-bit code for a delta or length, extension bytes appended to ext_bytes
    function logic [3:0] nibble_of(int unsigned v);
      if (v < 13) return v[3:0];
      if (v < 269) begin
        ext_bytes.insert(ext_bytes.size(), 8'(v - 13));
        return 4'd13;
      end
      ext_bytes.insert(ext_bytes.size(), 8'((v - 269) >> 8));
      ext_bytes.insert(ext_bytes.size(), 8'(v - 269));
      return 4'd14;
    endfunction

    // called on every accepted command beat; returns how many byte beats it causes
    function int note_command(logic [2:0] cmd, logic [15:0] number, logic [15:0] length,
                              logic [7:0] data);
      int n;
      int tl;
      logic [3:0] hd, hl;
      n  = 0;
      tl = token_len;
      if (cmd != cms_pkg::CMD_START && (cmd > cms_pkg::CMD_FINISH || failed)) return 0;
      case (cmd)
        cms_pkg::CMD_START: begin
          prev_option   = '0;
          payload_count = '0;
          marker_sent   = 1'b0;
          failed        = 1'b0;
          if (tl > 8) n = raise_error(cms_pkg::ST_TOKEN);
          else if (!(msg_code[7:5] == 3'd0 || msg_code[7:5] == 3'd2 ||
                     msg_code[7:5] == 3'd4 || msg_code[7:5] == 3'd5))
            n = raise_error(cms_pkg::ST_CLASS);
          else if (msg_code == 8'h00 && tl != 0) n = raise_error(cms_pkg::ST_EMPTY);
          else begin
            push_beat({2'b01, msg_type, token_len}, 1'b1, cms_pkg::ST_OK);
            push_beat(msg_code, 1'b1, cms_pkg::ST_OK);
            push_beat(msg_id[15:8], 1'b1, cms_pkg::ST_OK);
            push_beat(msg_id[7:0], 1'b1, cms_pkg::ST_OK);
            for (int i = 0; i < tl; i++)
              push_beat(token_value[8*(tl-1-i) +: 8], 1'b1, cms_pkg::ST_OK);
            n = 4 + tl;
          end
        end
        cms_pkg::CMD_OPT_HDR: begin
          if (msg_code == 8'h00) n = raise_error(cms_pkg::ST_EMPTY);
          else if (marker_sent) n = raise_error(cms_pkg::ST_ORDER);
          else if (length > cms_pkg::MaxOptionBytes) n = raise_error(cms_pkg::ST_OPTLONG);
          else if (number < prev_option) n = raise_error(cms_pkg::ST_ORDER);
          else begin
            ext_bytes.delete();
            hd = nibble_of(number - prev_option);
            hl = nibble_of(length);
            push_beat({hd, hl}, 1'b1, cms_pkg::ST_OK);
            foreach (ext_bytes[k]) push_beat(ext_bytes[k], 1'b1, cms_pkg::ST_OK);
            n = 1 + ext_bytes.size();
            prev_option = number;
          end
        end
        cms_pkg::CMD_OPT_VAL: begin
          if (msg_code == 8'h00) n = raise_error(cms_pkg::ST_EMPTY);
          else if (marker_sent) n = raise_error(cms_pkg::ST_ORDER);
          else begin
            push_beat(data, 1'b1, cms_pkg::ST_OK);
            n = 1;
          end
        end
        cms_pkg::CMD_PAYLOAD: begin
          if (msg_code == 8'h00) n = raise_error(cms_pkg::ST_EMPTY);
          else if (payload_count >= cms_pkg::MaxPayloadBytes)
            n = raise_error(cms_pkg::ST_LARGE);
          else begin
            if (!marker_sent) begin
              push_beat(PayloadMarker, 1'b1, cms_pkg::ST_OK);
              marker_sent = 1'b1;
              n = 1;
            end
            push_beat(data, 1'b1, cms_pkg::ST_OK);
            n++;
            if (payload_count < cms_pkg::CountMax) payload_count++;
          end
        end
        cms_pkg::CMD_FINISH: begin
          push_beat(8'h00, 1'b0, cms_pkg::ST_OK);
          n = 1;
        end
        default: ;
      endcase
      if (n > 0) expected_bytes[expected_bytes.size()-1].last = 1'b1;
      return n;
    endfunction

    function void check_byte(logic [7:0] data, logic valid, logic [2:0] st, logic last);
      coap_beat_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat: got byte %h valid %b status %0d last %b",
                 $time, data, valid, st, last);
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data || valid !== want.valid || st !== want.st ||
          last !== want.last) begin
        mismatches++;
        $display("%0t: beat mismatch: expected byte %h valid %b status %0d last %b,",
                 $time, want.data, want.valid, want.st, want.last,
                 " got byte %h valid %b status %0d last %b", data, valid, st, last);
      end
    endfunction
  endclass

  // block inputs, all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [2:0]  command = '0;
  logic [15:0] option_number = '0;
  logic [15:0] option_length = '0;
  logic [7:0]  data_byte = '0;
  logic        out_ready = 1'b0;
  // block outputs
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [2:0]  status;
  logic        last;

  coap_byte_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;         // command beats taken by the block
  int unsigned gap_max = 0;            // longest sender pause between bursts, 0 = none
  int unsigned burst_left = 0;
  int          ready_mode = ReadyAlways;
  int unsigned stall_phase = 0;

  coap_message_serializer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .option_number (option_number),
    .option_length (option_length),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .status        (status),
    .last          (last)
  );

  always #ClkHalf clk = ~clk;

  // receiver back-pressure, changed on the falling edge like every other input
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 7;
    case (ready_mode)
      ReadyAlways: out_ready = 1'b1;
      ReadyRandom: out_ready = ($urandom_range(0, 3) != 0);
      default:     out_ready = (stall_phase < 4);   // stalled while stall_phase is 4 to 6
    endcase
  end

  // sample both channels on the rising edge; the timeout lives here too
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d beats still expected", $time,
               sb.expected_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end else if (!rst) begin
      // a command beat taken at this edge cannot show up before the next beat out
      if (in_valid && in_ready)
        void'(sb.note_command(command, option_number, option_length, data_byte));
      if (out_valid && out_ready) sb.check_byte(out_byte, byte_valid, status, last);
    end
  end

  // one command beat: bursts of random length with random pauses in between;
  // valid stays up across back-to-back beats and only drops at a pause
  task automatic send_item(logic [2:0] cmd, logic [15:0] number, logic [15:0] length,
                           logic [7:0] data);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      = 1'b1;
    command       = cmd;
    option_number = number;
    option_length = length;
    data_byte     = data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // any command with any fields, including undecoded ones
  task automatic send_noise();
    send_item(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // stop sending, let every expected beat drain and give the block time to go quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // write all five registers back to back, only while the block is idle
  task automatic set_config(logic [1:0] mtype, logic [7:0] code, logic [15:0] id,
                            logic [3:0] tl, logic [63:0] token);
    logic [63:0] value [NumRegs];
    value[cms_pkg::REG_MSG_TYPE]    = 64'(mtype);
    value[cms_pkg::REG_MSG_CODE]    = 64'(code);
    value[cms_pkg::REG_MSG_ID]      = 64'(id);
    value[cms_pkg::REG_TOKEN_LEN]   = 64'(tl);
    value[cms_pkg::REG_TOKEN_VALUE] = token;
    for (int i = 0; i < NumRegs; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = 3'(i);
      cfg_data  = value[i];
      sb.write_reg(3'(i), value[i]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly a well-formed message: start, sorted options with values, payload, finish;
  // now and then noise, an option that goes backwards, an oversize length or
  // option material after the payload
  task automatic send_message();
    int unsigned num, len, r, n_pay;
    num = 0;
    send_item(cms_pkg::CMD_START, 16'($urandom), 16'($urandom), 8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 15) == 0) send_noise();
      r = $urandom_range(0, 19);
      if (r < 10) num += $urandom_range(0, 12);
      else if (r < 15) num += $urandom_range(13, 268);
      else if (r < 18) num += $urandom_range(269, 4000);
      else if (r == 18) num += $urandom_range(4000, 65535);
      else if (num != 0) num -= $urandom_range(1, num);   // out of order
      if (num > 65535) num = 65535;
      r = $urandom_range(0, 19);
      if (r == 0) len = $urandom_range(cms_pkg::MaxOptionBytes + 1, 65535);
      else if (r < 11) len = $urandom_range(0, 12);
      else if (r < 16) len = $urandom_range(13, 268);
      else len = $urandom_range(269, cms_pkg::MaxOptionBytes);
      send_item(cms_pkg::CMD_OPT_HDR, num[15:0], len[15:0], 8'($urandom));
      repeat ($urandom_range(0, 3))
        send_item(cms_pkg::CMD_OPT_VAL, 16'($urandom), 16'($urandom), 8'($urandom));
    end
    n_pay = $urandom_range(0, 8);
    repeat (n_pay)
      send_item(cms_pkg::CMD_PAYLOAD, 16'($urandom), 16'($urandom), 8'($urandom));
    if (n_pay != 0 && $urandom_range(0, 9) == 0)
      send_item($urandom_range(0, 1) ? cms_pkg::CMD_OPT_HDR : cms_pkg::CMD_OPT_VAL,
                16'(num + 1), 16'($urandom_range(0, 20)), 8'($urandom));
    if ($urandom_range(0, 15) == 0) send_noise();
    send_item(cms_pkg::CMD_FINISH, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned r;
    logic [7:0]  code;
    logic [3:0]  tl;

    sb = new();
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // registers still at reset: empty code, so message content is refused
    gap_max    = 0;
    ready_mode = ReadyPattern;
    send_item(cms_pkg::CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h3C);   // empty format, sets failed
    send_item(cms_pkg::CMD_OPT_VAL, 16'h0000, 16'h0000, 8'h11);   // swallowed while failed
    send_item(CmdUnused, 16'hFFFF, 16'hFFFF, 8'hFF);              // undecoded, no beat
    send_item(cms_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);     // bare 4-byte header
    send_item(cms_pkg::CMD_FINISH, 16'h0000, 16'h0000, 8'h00);
    send_item(cms_pkg::CMD_OPT_HDR, 16'h0000, 16'h0000, 8'h00);   // empty format again
    settle();

    // full header with an 8-byte token, then every nibble extension boundary
    ready_mode = ReadyRandom;
    set_config(2'd3, 8'h45, 16'hFFFF, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_item(cms_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
    send_item(cms_pkg::CMD_OPT_HDR, 16'd12, 16'd0, 8'h00);        // delta 12, no extension
    send_item(cms_pkg::CMD_OPT_HDR, 16'd25, 16'd13, 8'h00);       // one-byte extensions
    send_item(cms_pkg::CMD_OPT_VAL, 16'h0000, 16'h0000, 8'h00);
    send_item(cms_pkg::CMD_OPT_VAL, 16'h0000, 16'h0000, 8'hFF);
    send_item(cms_pkg::CMD_OPT_HDR, 16'd293, 16'd268, 8'h00);     // top of one-byte range
    send_item(cms_pkg::CMD_OPT_HDR, 16'd562, 16'd269, 8'h00);     // two-byte extensions
    send_item(cms_pkg::CMD_OPT_HDR, 16'd562, 16'd1024, 8'h00);    // repeated number
    send_item(cms_pkg::CMD_OPT_HDR, 16'd561, 16'd0, 8'h00);       // going backwards
    send_item(cms_pkg::CMD_FINISH, 16'h0000, 16'h0000, 8'h00);    // swallowed while failed
    send_item(cms_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
    send_item(cms_pkg::CMD_OPT_HDR, 16'hFFFF, 16'hFFFF, 8'h00);   // value too long
    send_item(cms_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
    send_item(cms_pkg::CMD_OPT_HDR, 16'hFFFF, 16'd1024, 8'h00);   // largest delta
    send_item(cms_pkg::CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h00);   // marker then byte
    send_item(cms_pkg::CMD_PAYLOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(cms_pkg::CMD_OPT_VAL, 16'h0000, 16'h0000, 8'h77);   // value after the marker
    settle();

    // start refused by the registers: token too long, bad class, empty with token
    set_config(2'd1, 8'h45, 16'h1234, 4'd15, '1);
    send_item(cms_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
    settle();
    set_config(2'd2, 8'hE0, 16'h0000, 4'd0, 64'h0);
    send_item(cms_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
    settle();
    set_config(2'd0, 8'h00, 16'h8001, 4'd1, 64'hA5);
    send_item(cms_pkg::CMD_START, 16'h0000, 16'h0000, 8'h00);
    settle();

    // random part: each phase has its own registers, sender pauses and stall style
    phase_no = 0;
    while (items_sent < ItemCount) begin
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      ready_mode = $urandom_range(ReadyAlways, ReadyPattern);
      if (phase_no == 0) begin
        // all-ones corner with no idling on either side
        gap_max    = 0;
        ready_mode = ReadyAlways;
        set_config(2'd3, 8'hBF, 16'hFFFF, 4'd8, '1);
      end else if (phase_no == 1) begin
        set_config(2'd0, 8'h00, 16'h0000, 4'd0, 64'h0);
      end else begin
        tl = 4'($urandom_range(0, 8));
        r  = $urandom_range(0, 3);
        code = {3'((r == 3) ? 5 : 2 * r), 5'($urandom)};
        r = $urandom_range(0, 15);
        if (r == 0) tl = 4'($urandom_range(9, 15));
        else if (r == 1) begin
          r = $urandom_range(0, 3);
          code[7:5] = 3'((r < 2) ? 2 * r + 1 : r + 4);
        end else if (r == 2) code = 8'h00;
        set_config(2'($urandom), code, 16'($urandom), tl, {$urandom, $urandom});
      end
      repeat ($urandom_range(2, 6))
        if (items_sent < ItemCount) send_message();
      settle();
      phase_no++;
    end

    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
design/cms_pkg.sv
design/cms_front.sv
design/cms_queue.sv
design/cms_back.sv
design/coap_message_serializer.sv
design/cms_checker.sv
tb/coap_message_serializer_tb.sv
